// ===== hw/rtl/multi_led_blink_controller_macros.svh =====
// Assertion macros for the LED blink controller.
// Used by the top level; each macro expects clk and rst in scope.
`ifndef MULTI_LED_BLINK_CONTROLLER_MACROS_SVH
`define MULTI_LED_BLINK_CONTROLLER_MACROS_SVH

`define MLBC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define MLBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/mlbc_pkg.sv =====
// Types and constants for the LED blink controller.
// Used by mlbc_ctrl and the top level; depends on nothing.
package mlbc_pkg;

  localparam int CNT_W = 16;
  localparam int OUT_W = 8;

  typedef enum logic [2:0] {
    OP_ON     = 3'd0,
    OP_OFF    = 3'd1,
    OP_TOGGLE = 3'd2,
    OP_BLINK  = 3'd3,
    OP_TICK   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_t;

  localparam logic [1:0] ADDR_ACTIVE_LOW = 2'd0;

  typedef struct packed {
    logic [2:0]       operation;
    logic [2:0]       led_index;
    logic [CNT_W-1:0] blink_half_period;
  } cmd_word_t;

  typedef struct packed {
    logic [OUT_W-1:0] pin_levels;
    logic [OUT_W-1:0] blinking_mask;
  } result_word_t;

endpackage

// ===== hw/rtl/mlbc_mem.sv =====
// Per-LED reload value and tick counter storage, one entry per LED.
// Synchronous memory with one write port and one registered read port.
module mlbc_mem #(
  parameter int DEPTH = 8,
  parameter int AW    = 3,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/mlbc_ctrl.sv =====
// Command sequencer: lit and blink-mode bits, the tick walk over the counter
// memory and the result word. Depends on mlbc_pkg and mlbc_mem.
module mlbc_ctrl import mlbc_pkg::*; #(
  parameter int NUM_LEDS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  cmd_word_t            cmd,
  input  logic [OUT_W-1:0]     active_low_mask,
  output logic                 busy,
  output logic                 result_valid,
  output result_word_t         result
);

  localparam int AW    = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam int PAD_W = (NUM_LEDS > OUT_W) ? NUM_LEDS : OUT_W;
  localparam logic [AW-1:0] LAST_IDX = AW'(NUM_LEDS - 1);

  state_t               state;
  state_t               state_next;
  logic [NUM_LEDS-1:0]  lit_bits;
  logic [NUM_LEDS-1:0]  blink_bits;
  logic [AW-1:0]        walk_idx;
  logic                 accept;
  logic                 idx_ok;
  logic [AW-1:0]        led_addr;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [2*CNT_W-1:0]   mem_wdata;
  logic [AW-1:0]        mem_raddr;
  logic [2*CNT_W-1:0]   mem_rdata;
  logic [CNT_W-1:0]     cnt_dec;
  logic                 cnt_hit;
  logic [PAD_W-1:0]     lit_pad;
  logic [PAD_W-1:0]     blink_pad;

  assign accept   = start && !busy;
  assign idx_ok   = 32'(cmd.led_index) < NUM_LEDS;
  assign led_addr = AW'(cmd.led_index);
  assign cnt_dec  = mem_rdata[CNT_W-1:0] - CNT_W'(1);
  assign cnt_hit  = (cnt_dec == '0);

  mlbc_mem #(
    .DEPTH (NUM_LEDS),
    .AW    (AW),
    .DW    (2 * CNT_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = walk_idx;
    mem_wdata  = {mem_rdata[2*CNT_W-1:CNT_W], cnt_dec};
    mem_raddr  = '0;
    unique case (state)
      ST_IDLE, ST_DONE: begin
        state_next = ST_IDLE;
        if (accept) begin
          if (cmd.operation == OP_TICK) begin
            state_next = ST_WALK;
          end else begin
            state_next = ST_DONE;
            if (cmd.operation == OP_BLINK && idx_ok) begin
              mem_we    = 1'b1;
              mem_waddr = led_addr;
              mem_wdata = {cmd.blink_half_period, cmd.blink_half_period};
            end
          end
        end
      end
      ST_WALK: begin
        mem_we = blink_bits[walk_idx];
        if (cnt_hit) begin
          mem_wdata = {mem_rdata[2*CNT_W-1:CNT_W], mem_rdata[2*CNT_W-1:CNT_W]};
        end
        if (walk_idx == LAST_IDX) begin
          state_next = ST_DONE;
        end else begin
          mem_raddr = walk_idx + AW'(1);
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lit_bits   <= '0;
      blink_bits <= '0;
      walk_idx   <= '0;
    end else if (state == ST_WALK) begin
      if (blink_bits[walk_idx] && cnt_hit) begin
        lit_bits[walk_idx] <= ~lit_bits[walk_idx];
      end
      walk_idx <= (walk_idx == LAST_IDX) ? '0 : walk_idx + AW'(1);
    end else if (accept && idx_ok) begin
      unique case (cmd.operation)
        OP_ON: begin
          lit_bits[led_addr]   <= 1'b1;
          blink_bits[led_addr] <= 1'b0;
        end
        OP_OFF: begin
          lit_bits[led_addr]   <= 1'b0;
          blink_bits[led_addr] <= 1'b0;
        end
        OP_TOGGLE: begin
          lit_bits[led_addr]   <= ~lit_bits[led_addr];
          blink_bits[led_addr] <= 1'b0;
        end
        OP_BLINK: begin
          blink_bits[led_addr] <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign lit_pad              = PAD_W'(lit_bits);
  assign blink_pad            = PAD_W'(blink_bits);
  assign busy                 = (state == ST_WALK);
  assign result_valid         = (state == ST_DONE);
  assign result.pin_levels    = lit_pad[OUT_W-1:0] ^ active_low_mask;
  assign result.blinking_mask = blink_pad[OUT_W-1:0];

endmodule

// ===== hw/rtl/multi_led_blink_controller.sv =====
// Top level of the LED blink controller: register port and command sequencer.
// Depends on mlbc_pkg, mlbc_ctrl and the assertion macro header.
//
//   Channel   Handshake                 Payload
//   command   start / busy              cmd (cmd_word_t)
//   result    result_valid (strobe)     result (result_word_t)
//   config    psel/penable/pwrite       paddr, pwdata, prdata
//
// On, off, toggle, blink and unknown commands go straight to the result; a tick
// first walks the counter memory, reading each counter entry and writing it back,
// and then shows the result.
// The result appears for one cycle after the work ends; a new command may be
// accepted in that cycle. The receiver takes every result word and never stalls.
// Reset clears the lit and blink-mode bits and the mask.
`include "multi_led_blink_controller_macros.svh"

module multi_led_blink_controller import mlbc_pkg::*; #(
  parameter int NUM_LEDS = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  output logic         busy,
  input  cmd_word_t    cmd,
  output logic         result_valid,
  output result_word_t result,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [1:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [OUT_W-1:0] active_low_mask;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_ACTIVE_LOW) ? 32'(active_low_mask) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_low_mask <= '0;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_ACTIVE_LOW) begin
      active_low_mask <= pwdata[OUT_W-1:0];
    end
  end

  mlbc_ctrl #(
    .NUM_LEDS (NUM_LEDS)
  ) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .cmd             (cmd),
    .active_low_mask (active_low_mask),
    .busy            (busy),
    .result_valid    (result_valid),
    .result          (result)
  );

  `MLBC_ASSERT_NEXT(a_accept_progress, start && !busy, busy || result_valid, "no progress")
  `MLBC_ASSERT_SAME(a_result_not_busy, result_valid, !busy, "result shown while walking counters")
  `MLBC_ASSERT_NEXT(a_result_once, result_valid && !start, !result_valid, "result repeated")

endmodule

// ===== test/multi_led_blink_controller_tb.sv =====
// Self-checking testbench for multi_led_blink_controller: a directed command table, then
// random command words in phases of different sender idling and active-low settings.
// Depends on mlbc_pkg and the RTL of the block; each result word is checked against the predictor or a table value.
module multi_led_blink_controller_tb import mlbc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_LEDS = 8;
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 3 * (NUM_LEDS + 1);
  localparam int PHASE_WORDS = 365;
  localparam logic [2:0] OP_RSVD_5 = 3'd5;
  localparam logic [2:0] OP_RSVD_6 = 3'd6;
  localparam logic [2:0] OP_RSVD_7 = 3'd7;

  typedef struct packed {
    logic [2:0]   op;
    logic [2:0]   led;
    logic [15:0]  half;
    logic         known;
    result_word_t want;
  } script_row_t;

  localparam script_row_t SCRIPT [0:24] = '{
    '{OP_TICK,   3'd0, 16'h0000, 1'b1, '{8'h00, 8'h00}},
    '{OP_RSVD_5, 3'd3, 16'hFFFF, 1'b1, '{8'h00, 8'h00}},
    '{OP_RSVD_6, 3'd7, 16'hFFFF, 1'b1, '{8'h00, 8'h00}},
    '{OP_RSVD_7, 3'd0, 16'h0000, 1'b1, '{8'h00, 8'h00}},
    '{OP_ON,     3'd0, 16'h0000, 1'b1, '{8'h01, 8'h00}},
    '{OP_ON,     3'd7, 16'hFFFF, 1'b1, '{8'h81, 8'h00}},
    '{OP_OFF,    3'd0, 16'h0000, 1'b0, '{8'h00, 8'h00}},
    '{OP_TOGGLE, 3'd7, 16'h0000, 1'b0, '{8'h00, 8'h00}},
    '{OP_TOGGLE, 3'd3, 16'h0000, 1'b0, '{8'h00, 8'h00}},
    '{OP_BLINK,  3'd3, 16'h0001, 1'b0, '{8'h00, 8'h00}},
    '{OP_TICK,   3'd0, 16'h0000, 1'b0, '{8'h00, 8'h00}},
    '{OP_TICK,   3'd7, 16'hFFFF, 1'b0, '{8'h00, 8'h00}},
    '{OP_BLINK,  3'd5, 16'h0000, 1'b0, '{8'h00, 8'h00}},
    '{OP_TICK,   3'd0, 16'h0000, 1'b0, '{8'h00, 8'h00}},
    '{OP_BLINK,  3'd0, 16'hFFFF, 1'b0, '{8'h00, 8'h00}},
    '{OP_TICK,   3'd0, 16'h0000, 1'b0, '{8'h00, 8'h00}},
    '{OP_BLINK,  3'd7, 16'h0002, 1'b0, '{8'h00, 8'h00}},
    '{OP_TICK,   3'd0, 16'h0000, 1'b0, '{8'h00, 8'h00}},
    '{OP_TICK,   3'd0, 16'h0000, 1'b0, '{8'h00, 8'h00}},
    '{OP_ON,     3'd3, 16'h0000, 1'b0, '{8'h00, 8'h00}},
    '{OP_OFF,    3'd7, 16'h0000, 1'b0, '{8'h00, 8'h00}},
    '{OP_TOGGLE, 3'd5, 16'h0000, 1'b0, '{8'h00, 8'h00}},
    '{OP_BLINK,  3'd6, 16'hAAAA, 1'b0, '{8'h00, 8'h00}},
    '{OP_BLINK,  3'd1, 16'h5555, 1'b0, '{8'h00, 8'h00}},
    '{OP_TICK,   3'd0, 16'h0000, 1'b0, '{8'h00, 8'h00}}
  };

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         start = 1'b0;
  logic         busy;
  cmd_word_t    cmd = '0;
  logic         result_valid;
  result_word_t result;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [1:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  logic [7:0]   lit_now = '0;
  logic [7:0]   blink_now = '0;
  logic [7:0]   low_mask = '0;
  logic [15:0]  reload_ticks [NUM_LEDS];
  logic [15:0]  ticks_left [NUM_LEDS];
  result_word_t pending_levels [$];
  int           mismatches = 0;
  int           idle_pct = 0;
  int           quiet_cycles = 0;

  multi_led_blink_controller #(.NUM_LEDS(NUM_LEDS)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .result_valid(result_valid), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic apply_led_command(input cmd_word_t c, output result_word_t r);
    logic [7:0] sel;
    sel = 8'b1 << c.led_index;
    if (c.operation == OP_TICK) begin
      for (int i = 0; i < NUM_LEDS; i++) begin
        if (blink_now[i]) begin
          ticks_left[i] = ticks_left[i] - 16'd1;
          if (ticks_left[i] == 16'd0) begin
            lit_now[i] = ~lit_now[i];
            ticks_left[i] = reload_ticks[i];
          end
        end
      end
    end else if (c.led_index < NUM_LEDS) begin
      case (c.operation)
        OP_ON: begin
          lit_now = lit_now | sel;
          blink_now = blink_now & ~sel;
        end
        OP_OFF: begin
          lit_now = lit_now & ~sel;
          blink_now = blink_now & ~sel;
        end
        OP_TOGGLE: begin
          lit_now = lit_now ^ sel;
          blink_now = blink_now & ~sel;
        end
        OP_BLINK: begin
          blink_now = blink_now | sel;
          reload_ticks[c.led_index] = c.blink_half_period;
          ticks_left[c.led_index] = c.blink_half_period;
        end
        default: begin
        end
      endcase
    end
    r.pin_levels = lit_now ^ low_mask;
    r.blinking_mask = blink_now;
  endtask

  task automatic log_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Holds the word on the port until an edge with busy low takes it.
  task automatic send_word(input cmd_word_t c, input logic known, input result_word_t want);
    result_word_t r;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
    apply_led_command(c, r);
    pending_levels.push_back(known ? want : r);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_active_low(input logic [7:0] v);
    if (prdata !== {24'd0, low_mask})
      log_mismatch($sformatf("prdata got %h want %h", prdata, {24'd0, low_mask}));
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_ACTIVE_LOW;
    pwdata <= {24'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    low_mask = v;
  endtask

  function automatic cmd_word_t random_word();
    cmd_word_t c;
    int pick;
    pick = $urandom_range(99);
    c.led_index = 3'($urandom_range(NUM_LEDS - 1));
    c.blink_half_period = 16'($urandom_range(65535));
    if (pick < 40) c.operation = OP_TICK;
    else if (pick < 52) c.operation = OP_ON;
    else if (pick < 64) c.operation = OP_OFF;
    else if (pick < 76) c.operation = OP_TOGGLE;
    else if (pick < 96) c.operation = OP_BLINK;
    else c.operation = 3'($urandom_range(OP_RSVD_5, OP_RSVD_7));
    if (c.operation == OP_BLINK) begin
      pick = $urandom_range(99);
      if (pick < 70) c.blink_half_period = 16'($urandom_range(1, 6));
      else if (pick < 90) c.blink_half_period = 16'($urandom_range(7, 40));
    end
    return c;
  endfunction

  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (pending_levels.size() == 0) begin
        log_mismatch($sformatf("unexpected result word pins=%h blink=%h",
                               result.pin_levels, result.blinking_mask));
      end else begin
        if (result.pin_levels !== pending_levels[0].pin_levels)
          log_mismatch($sformatf("pin_levels got %h want %h",
                                 result.pin_levels, pending_levels[0].pin_levels));
        if (result.blinking_mask !== pending_levels[0].blinking_mask)
          log_mismatch($sformatf("blinking_mask got %h want %h",
                                 result.blinking_mask, pending_levels[0].blinking_mask));
        void'(pending_levels.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    cmd_word_t c;
    logic [7:0] mask_v;
    for (int i = 0; i < NUM_LEDS; i++) begin
      reload_ticks[i] = '0;
      ticks_left[i] = '0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_active_low(8'h00);
    for (int n = 0; n < $size(SCRIPT); n++) begin
      c.operation = SCRIPT[n].op;
      c.led_index = SCRIPT[n].led;
      c.blink_half_period = SCRIPT[n].half;
      send_word(c, SCRIPT[n].known, SCRIPT[n].want);
    end
    for (int ph = 0; ph < 5; ph++) begin
      drain_results();
      case (ph)
        0: mask_v = 8'hFF;
        2: mask_v = 8'h00;
        default: mask_v = 8'($urandom_range(255));
      endcase
      write_active_low(mask_v);
      case (ph % 3)
        0: idle_pct = 0;
        1: idle_pct = 87;
        default: idle_pct = 25;
      endcase
      for (int n = 0; n < PHASE_WORDS; n++) send_word(random_word(), 1'b0, '0);
    end
    drain_results();
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
